// File: src/masked_bitsliced_comparator_top_macros.svh
// Assertion macros for the masked bitsliced comparator.
// Included by the modules that carry concurrent assertions; needs clk and rst in scope.
`ifndef MASKED_BITSLICED_COMPARATOR_TOP_MACROS_SVH
`define MASKED_BITSLICED_COMPARATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside of reset.
`define MBC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mbc assertion failed");

// Checked at every clock edge, reset included.
`define MBC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mbc reset assertion failed");

`else

`define MBC_ASSERT(label, prop)
`define MBC_ASSERT_RST(label, prop)

`endif

`endif

// File: src/mbc_pkg.sv
// Shared types, constants and helpers of the masked bitsliced comparator.
// No dependencies; imported by every module of the block.
package mbc_pkg;

  // Default number of Boolean shares the datapath is built for.
  localparam int MAX_SHARES_DEF = 3;

  // Lanes per bit plane; bits at or above this are ignored.
  localparam int LANES = 32;

  localparam logic [31:0] LANE_MASK =
    (LANES >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << LANES) - 64'd1);

  // Share count register value after reset.
  localparam logic [1:0] SHARES_RESET = 2'd2;

  typedef logic [31:0] word_t;
  typedef logic [1:0]  share_cnt_t;

  // Comparison kinds.
  typedef enum logic [1:0] {
    OP_LEQ = 2'd0,
    OP_LT  = 2'd1,
    OP_EQ  = 2'd2
  } op_t;

  // One bit plane request.
  typedef struct packed {
    logic [1:0] op;
    word_t      left_share0;
    word_t      left_share1;
    word_t      left_share2;
    word_t      right_share0;
    word_t      right_share1;
    word_t      right_share2;
    word_t      rand_01;
    word_t      rand_02;
    word_t      rand_12;
    logic       last_plane;
  } item_t;

  // One comparison result.
  typedef struct packed {
    word_t result_share0;
    word_t result_share1;
    word_t result_share2;
  } result_t;

  // Unused op code is treated as equality.
  function automatic op_t decode_op(logic [1:0] code);
    op_t kind;
    case (code)
      OP_LEQ:  kind = OP_LEQ;
      OP_LT:   kind = OP_LT;
      default: kind = OP_EQ;
    endcase
    return kind;
  endfunction

endpackage

// File: src/mbc_masked_and.sv
// ISW masked AND gadget over up to three Boolean shares of 32 lanes.
// Purely combinational; depends on mbc_pkg.
module mbc_masked_and import mbc_pkg::*; #(
  parameter int MAX_SHARES = MAX_SHARES_DEF
) (
  input  word_t      x [MAX_SHARES],
  input  word_t      y [MAX_SHARES],
  input  word_t      rand_01,
  input  word_t      rand_02,
  input  word_t      rand_12,
  input  share_cnt_t n,
  output word_t      z [MAX_SHARES]
);

  // Pair mask shared by shares i and j (i differs from j).
  function automatic word_t pair_mask(int i, int j, word_t r01, word_t r02, word_t r12);
    word_t r;
    case (i + j)
      1:       r = r01;
      2:       r = r02;
      default: r = r12;
    endcase
    return r & LANE_MASK;
  endfunction

  // Each share: own product plus the masked cross terms with every other share in use.
  always_comb begin
    for (int i = 0; i < MAX_SHARES; i++) begin
      z[i] = '0;
      if (2'(i) < n) begin
        z[i] = x[i] & y[i];
        for (int j = 0; j < MAX_SHARES; j++) begin
          if (j != i && 2'(j) < n) begin
            z[i] ^= (~x[i] & pair_mask(i, j, rand_01, rand_02, rand_12))
                  ^ (x[i] & (y[j] ^ pair_mask(i, j, rand_01, rand_02, rand_12)));
          end
        end
      end
      z[i] &= LANE_MASK;
    end
  end

endmodule

// File: src/mbc_plane.sv
// Per-plane update of the running borrow or difference shares and result forming.
// Combinational; depends on mbc_pkg and mbc_masked_and.
module mbc_plane import mbc_pkg::*; #(
  parameter int MAX_SHARES = MAX_SHARES_DEF
) (
  input  item_t      item,
  input  logic       first,
  input  op_t        held_op,
  input  word_t      running [MAX_SHARES],
  input  share_cnt_t n,
  output op_t        op_now,
  output word_t      run_next [MAX_SHARES],
  output result_t    res
);

  word_t lin [3];
  word_t rin [3];
  word_t l [MAX_SHARES];
  word_t rt [MAX_SHARES];
  word_t run_eff [MAX_SHARES];
  word_t a [MAX_SHARES];
  word_t b [MAX_SHARES];
  word_t p [MAX_SHARES];
  word_t res_w [3];

  // The kind is latched on the first plane of a comparison.
  assign op_now = first ? decode_op(item.op) : held_op;

  assign lin[0] = item.left_share0;
  assign lin[1] = item.left_share1;
  assign lin[2] = item.left_share2;
  assign rin[0] = item.right_share0;
  assign rin[1] = item.right_share1;
  assign rin[2] = item.right_share2;

  // Operand selection, unused shares zeroed, swap for strict less-than.
  always_comb begin
    for (int i = 0; i < MAX_SHARES; i++) begin
      if (2'(i) < n) begin
        l[i]  = (op_now == OP_LT) ? (rin[i] & LANE_MASK) : (lin[i] & LANE_MASK);
        rt[i] = (op_now == OP_LT) ? (lin[i] & LANE_MASK) : (rin[i] & LANE_MASK);
      end else begin
        l[i]  = '0;
        rt[i] = '0;
      end
      run_eff[i] = (first || 2'(i) >= n) ? '0 : running[i];
    end
  end

  // Gadget operands: negated difference for equality, borrow chain otherwise.
  always_comb begin
    for (int i = 0; i < MAX_SHARES; i++) begin
      if (op_now == OP_EQ) begin
        a[i] = run_eff[i];
        b[i] = l[i] ^ rt[i];
      end else begin
        a[i] = rt[i] ^ run_eff[i];
        b[i] = l[i] ^ run_eff[i];
      end
    end
    if (op_now == OP_EQ) begin
      a[0] ^= LANE_MASK;
      b[0] ^= LANE_MASK;
    end
  end

  mbc_masked_and #(.MAX_SHARES(MAX_SHARES)) u_and (
    .x       (a),
    .y       (b),
    .rand_01 (item.rand_01),
    .rand_02 (item.rand_02),
    .rand_12 (item.rand_12),
    .n       (n),
    .z       (p)
  );

  // New running shares.
  always_comb begin
    for (int i = 0; i < MAX_SHARES; i++) begin
      if (op_now == OP_EQ) begin
        run_next[i] = first ? (l[i] ^ rt[i]) : p[i];
      end else begin
        run_next[i] = (p[i] ^ l[i]) & LANE_MASK;
      end
    end
    if (op_now == OP_EQ && !first) begin
      run_next[0] ^= LANE_MASK;
    end
  end

  // Result shares: share 0 is inverted unless the kind is strict less-than.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_w[i] = '0;
    end
    for (int i = 0; i < MAX_SHARES; i++) begin
      res_w[i] = run_next[i] & LANE_MASK;
    end
    if (op_now != OP_LT) begin
      res_w[0] = (res_w[0] ^ LANE_MASK) & LANE_MASK;
    end
  end

  assign res.result_share0 = res_w[0];
  assign res.result_share1 = res_w[1];
  assign res.result_share2 = res_w[2];

endmodule

// File: src/masked_bitsliced_comparator_top.sv
// Top level of the masked bitsliced comparator: input register, comparison state,
// result register and share count register. Depends on mbc_pkg and mbc_plane.
//
//   channel   | signals                          | moves
//   ----------+----------------------------------+----------------------------------
//   item      | item_valid, item_stall, item     | one bit plane request, LSB first
//   result    | result_valid, result_stall, result | shares of one comparison result
//   config    | cfg_wen, cfg_wdata               | shares in use register
//
// One bit plane per cycle while no last plane waits for room in the result register:
// a request is taken into the input register, from which the plane logic updates the
// running shares and, on the last plane, loads the result register. Reset (rst,
// synchronous) empties both registers and starts a new comparison. A held result
// stalls the input only while the input register holds a last plane; other planes
// keep moving.
`include "masked_bitsliced_comparator_top_macros.svh"

module masked_bitsliced_comparator_top import mbc_pkg::*; #(
  parameter int MAX_SHARES = MAX_SHARES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  input  logic       cfg_wen,
  input  logic [1:0] cfg_wdata
);

  logic       s1_valid;
  item_t      s1_item;
  share_cnt_t shares_in_use;
  share_cnt_t n;
  word_t      running [MAX_SHARES];
  logic       expect_first;
  op_t        held_op;
  op_t        op_now;
  word_t      run_next [MAX_SHARES];
  result_t    res_next;
  logic       out_free;
  logic       s1_go;

  // Share count, clamped to the range the datapath supports.
  always_comb begin
    n = shares_in_use;
    if (n == 2'd0) begin
      n = 2'd1;
    end
    if (n > 2'(MAX_SHARES)) begin
      n = 2'(MAX_SHARES);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      shares_in_use <= SHARES_RESET;
    end else if (cfg_wen) begin
      shares_in_use <= cfg_wdata;
    end
  end

  // Flow control: a last plane waits only for room in the result register.
  assign out_free   = !result_valid || !result_stall;
  assign s1_go      = s1_valid && (!s1_item.last_plane || out_free);
  assign item_stall = s1_valid && !s1_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  mbc_plane #(.MAX_SHARES(MAX_SHARES)) u_plane (
    .item     (s1_item),
    .first    (expect_first),
    .held_op  (held_op),
    .running  (running),
    .n        (n),
    .op_now   (op_now),
    .run_next (run_next),
    .res      (res_next)
  );

  // Comparison state, advanced once per processed plane.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SHARES; i++) begin
        running[i] <= '0;
      end
      expect_first <= 1'b1;
      held_op      <= OP_LEQ;
    end else if (s1_go) begin
      for (int i = 0; i < MAX_SHARES; i++) begin
        running[i] <= run_next[i];
      end
      expect_first <= s1_item.last_plane;
      held_op      <= op_now;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_item.last_plane) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item.last_plane) begin
      result <= res_next;
    end
  end

  // A plane that is not the last leaves the block inside a comparison.
  `MBC_ASSERT(a_mid_plane, (s1_go && !s1_item.last_plane) |=> !expect_first)
  // A last plane never overruns a result that is still held.
  `MBC_ASSERT(a_no_overrun, (s1_valid && s1_item.last_plane && !out_free) |-> item_stall)
  // A freshly loaded result always closes the comparison.
  `MBC_ASSERT(a_result_closes, $rose(result_valid) |-> expect_first)
  // Reset empties both registers and starts a new comparison.
  `MBC_ASSERT_RST(a_reset, rst |=> (expect_first && !s1_valid && !result_valid))

endmodule

// File: tb/masked_bitsliced_comparator_top_test.sv
// Self-checking testbench for masked_bitsliced_comparator_top: random and directed bit planes,
// a bit-exact predictor of the masked comparison and an in-order result scoreboard.
// Depends on mbc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module masked_bitsliced_comparator_top_test;
  import mbc_pkg::*;

  typedef logic [2:0][31:0] trio_t;

  localparam int IDLE_PCT      = 7;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_PLANES  = 80;

  // Operand relations used when building a comparison.
  localparam int DIFF_RANDOM = 0;
  localparam int DIFF_SPARSE = 1;
  localparam int DIFF_NONE   = 2;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  item_t      item = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_wen = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;

  // Requests waiting to be offered, and results the block still owes.
  item_t   planes_pending[$];
  result_t predicted_results[$];

  // Predictor copy of the block's state and register.
  logic [1:0] cfg_shares = SHARES_RESET;
  trio_t      run_sh = '0;
  bit         new_comparison = 1'b1;
  op_t        held_kind = OP_LEQ;

  bit calm = 1'b0;
  int rx_hold_left = 0;
  int fail_count = 0;
  int planes_sent = 0;
  int results_checked = 0;
  int cycles = 0;

  masked_bitsliced_comparator_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata)
  );

  always #10 clk = ~clk;

  // A share count of zero acts as one; the two-bit field cannot exceed three.
  function automatic int active_share_count();
    return (cfg_shares == 2'd0) ? 1 : int'(cfg_shares);
  endfunction

  // Masked AND over the shares in use, with one pair mask per pair of shares.
  function automatic trio_t masked_and_shares(trio_t x, trio_t y, word_t r01, word_t r02,
                                              word_t r12, int n);
    trio_t z;
    word_t pm [3][3];
    word_t zi;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) pm[i][j] = '0;
    pm[0][1] = r01; pm[1][0] = r01;
    pm[0][2] = r02; pm[2][0] = r02;
    pm[1][2] = r12; pm[2][1] = r12;
    for (int i = 0; i < 3; i++) begin
      zi = '0;
      if (i < n) begin
        zi = x[i] & y[i];
        for (int j = 0; j < n; j++)
          if (j != i) zi ^= (~x[i] & pm[i][j]) ^ (x[i] & (y[j] ^ pm[i][j]));
      end
      z[i] = zi & LANE_MASK;
    end
    return z;
  endfunction

  // Advance the predicted comparison by one accepted plane; the last plane yields a result.
  task automatic predict_plane(input item_t rq);
    trio_t lsh, rsh, lft, rgt, a, b, p;
    word_t lv, rv;
    int n;
    result_t res;
    n = active_share_count();
    lsh = {rq.left_share2, rq.left_share1, rq.left_share0};
    rsh = {rq.right_share2, rq.right_share1, rq.right_share0};
    if (new_comparison) begin
      held_kind = (rq.op == OP_LEQ) ? OP_LEQ : (rq.op == OP_LT) ? OP_LT : OP_EQ;
      run_sh = '0;
    end
    for (int i = 0; i < 3; i++) begin
      lv = (i < n) ? lsh[i] & LANE_MASK : '0;
      rv = (i < n) ? rsh[i] & LANE_MASK : '0;
      // Less-than is less-or-equal with the operands swapped.
      lft[i] = (held_kind == OP_LT) ? rv : lv;
      rgt[i] = (held_kind == OP_LT) ? lv : rv;
      if (i >= n) run_sh[i] = '0;
    end
    if (held_kind == OP_EQ) begin
      if (new_comparison) begin
        run_sh = lft ^ rgt;
      end else begin
        a = run_sh;
        b = lft ^ rgt;
        a[0] ^= LANE_MASK;
        b[0] ^= LANE_MASK;
        run_sh = masked_and_shares(a, b, rq.rand_01 & LANE_MASK, rq.rand_02 & LANE_MASK,
                                   rq.rand_12 & LANE_MASK, n);
        run_sh[0] ^= LANE_MASK;
      end
    end else begin
      a = rgt ^ run_sh;
      b = lft ^ run_sh;
      p = masked_and_shares(a, b, rq.rand_01 & LANE_MASK, rq.rand_02 & LANE_MASK,
                            rq.rand_12 & LANE_MASK, n);
      for (int i = 0; i < 3; i++) run_sh[i] = (p[i] ^ lft[i]) & LANE_MASK;
    end
    if (rq.last_plane) begin
      res.result_share0 = (run_sh[0] ^ ((held_kind != OP_LT) ? LANE_MASK : '0)) & LANE_MASK;
      res.result_share1 = run_sh[1] & LANE_MASK;
      res.result_share2 = run_sh[2] & LANE_MASK;
      predicted_results.push_back(res);
      new_comparison = 1'b1;
    end else begin
      new_comparison = 1'b0;
    end
  endtask

  // Split plain left and right planes into fresh shares for the current share count.
  function automatic item_t build_plane(logic [1:0] op_code, bit last, word_t lv, word_t rv);
    item_t rq;
    word_t ls1, ls2, rs1, rs2;
    int n;
    n = active_share_count();
    ls1 = $urandom; ls2 = $urandom;
    rs1 = $urandom; rs2 = $urandom;
    rq.op = op_code;
    rq.left_share0 = lv ^ ((n >= 2) ? ls1 : '0) ^ ((n >= 3) ? ls2 : '0);
    rq.left_share1 = ls1;
    rq.left_share2 = ls2;
    rq.right_share0 = rv ^ ((n >= 2) ? rs1 : '0) ^ ((n >= 3) ? rs2 : '0);
    rq.right_share1 = rs1;
    rq.right_share2 = rs2;
    rq.rand_01 = $urandom;
    rq.rand_02 = $urandom;
    rq.rand_12 = $urandom;
    rq.last_plane = last;
    return rq;
  endfunction

  // Queue one comparison of the given length; later planes carry a random op code,
  // which the block must ignore.
  task automatic queue_comparison(input logic [1:0] op_code, input int planes,
                                  input int relation, input bit closes);
    word_t lv, rv;
    for (int k = 0; k < planes; k++) begin
      lv = $urandom;
      case (relation)
        DIFF_NONE:   rv = lv;
        DIFF_SPARSE: rv = lv ^ ($urandom & $urandom & $urandom & $urandom);
        default:     rv = $urandom;
      endcase
      planes_pending.push_back(build_plane((k == 0) ? op_code : 2'($urandom_range(0, 3)),
                                           closes && (k == planes - 1), lv, rv));
    end
  endtask

  // Hold back until every request is taken and every result has come, then let the
  // block finish any plane still in flight.
  task automatic settle();
    while (planes_pending.size() != 0 || item_valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_shares(input logic [1:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    cfg_shares = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Request driver: offers queued planes with random gaps and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_plane(item);
        planes_sent++;
      end
      if (!item_valid || !item_stall) begin
        if (planes_pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          item <= planes_pending.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted result against the oldest prediction and
  // drives the result stall, including the long hold-off.
  always @(posedge clk) begin
    trio_t want, got;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result: %h %h %h", result.result_share0, result.result_share1,
                 result.result_share2);
          fail_count++;
        end else begin
          want = {predicted_results[0].result_share2, predicted_results[0].result_share1,
                  predicted_results[0].result_share0};
          got = {result.result_share2, result.result_share1, result.result_share0};
          void'(predicted_results.pop_front());
          for (int i = 0; i < 3; i++)
            if (got[i] !== want[i]) begin
              $error("result_share%0d mismatch: expected %h, actual %h", i, want[i], got[i]);
              fail_count++;
            end
          results_checked++;
        end
      end
      if (rx_hold_left > 0) begin
        result_stall <= 1'b1;
        rx_hold_left--;
      end else begin
        result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("masked_bitsliced_comparator_top_test NOT OK");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    logic [1:0] phase_shares [8];
    item_t rq;
    int queued;
    int planes;
    phase_shares = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, every op code and short equal and unequal comparisons.
    rq = '0;
    rq.last_plane = 1'b1;
    planes_pending.push_back(rq);
    rq = '1;
    planes_pending.push_back(rq);
    rq.op = OP_LT;
    planes_pending.push_back(rq);
    queue_comparison(OP_EQ, 3, DIFF_NONE, 1);
    queue_comparison(OP_LT, 2, DIFF_RANDOM, 1);
    queue_comparison(OP_LEQ, 2, DIFF_NONE, 1);
    queue_comparison(2'd3, 1, DIFF_SPARSE, 1);
    queue_comparison(OP_EQ, 4, DIFF_SPARSE, 1);
    settle();

    // A share count of zero behaves as a single share.
    write_shares(2'd0);
    queue_comparison(OP_LEQ, 2, DIFF_RANDOM, 1);
    queue_comparison(OP_EQ, 2, DIFF_NONE, 1);
    settle();

    // Share count changed in the middle of a comparison.
    queue_comparison(OP_LT, 2, DIFF_RANDOM, 0);
    settle();
    write_shares(2'd3);
    queue_comparison(OP_LEQ, 2, DIFF_RANDOM, 1);

    // Random phases, each under a share setting taken from phase_shares.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      write_shares(phase_shares[ph]);
      calm = (ph == 4);
      if (ph == 2) begin
        // Hold results back while single-plane requests keep coming.
        rx_hold_left = 150;
        for (int k = 0; k < 40; k++)
          queue_comparison(2'($urandom_range(0, 3)), 1, $urandom_range(0, 2), 1);
      end
      queued = 0;
      while (queued < PHASE_PLANES) begin
        if ($urandom_range(0, 99) < 85) begin
          planes = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
          queue_comparison(2'($urandom_range(0, 3)), planes, $urandom_range(0, 2), 1);
          queued += planes;
        end else begin
          planes_pending.push_back(build_plane(2'($urandom_range(0, 3)),
                                               bit'($urandom_range(0, 1)), $urandom, $urandom));
          queued++;
        end
      end
    end
    settle();
    calm = 1'b0;

    $display("Sent %0d bit-plane requests and checked %0d comparison results,", planes_sent,
             results_checked);
    $display("covering share counts 0 to 3, all op codes, gaps and a long result hold-off.");
    if (fail_count == 0) begin
      $display("masked_bitsliced_comparator_top_test OK");
    end else begin
      $display("masked_bitsliced_comparator_top_test NOT OK");
    end
    $finish;
  end

endmodule

// File: masked_bitsliced_comparator_top.f
+incdir+src
src/mbc_pkg.sv
src/mbc_masked_and.sv
src/mbc_plane.sv
src/masked_bitsliced_comparator_top.sv
tb/masked_bitsliced_comparator_top_test.sv
